FILE: hw/rtl/sacl_pkg.sv
// Shared types and codes for the set-associative LRU cache model.
package sacl_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_INSTR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  localparam int unsigned TagW = 32;
  localparam int unsigned AgeW = 32;

  typedef struct packed {
    logic            valid;
    logic [TagW-1:0] tag;
    logic [AgeW-1:0] age;
  } line_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_res_t;

endpackage

FILE: hw/rtl/sacl_store.sv
// Line storage: one row per set, registered read, single write port.
module sacl_store #(
  parameter int unsigned WAYS     = 4,
  parameter int unsigned SET_W    = 6,
  parameter int unsigned NUM_SETS = 64
) (
  input  logic                         clk_i,
  input  logic [SET_W-1:0]             rd_addr_i,
  output sacl_pkg::line_t [WAYS-1:0]   rd_row_o,
  input  logic                         wr_en_i,
  input  logic [SET_W-1:0]             wr_addr_i,
  input  sacl_pkg::line_t [WAYS-1:0]   wr_row_i
);
  import sacl_pkg::*;

  line_t [WAYS-1:0] mem_q [NUM_SETS];
  line_t [WAYS-1:0] rd_row_q;

  // read returns the old row when the same row is written at the same edge
  always_ff @(posedge clk_i) begin
    rd_row_q <= mem_q[rd_addr_i];
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
  end

  assign rd_row_o = rd_row_q;

endmodule

FILE: hw/rtl/sacl_lookup.sv
// Hit detection, victim choice and LRU age update for one set.
module sacl_lookup #(
  parameter int unsigned WAYS = 4
) (
  input  sacl_pkg::line_t [WAYS-1:0]   row_i,
  input  logic [sacl_pkg::TagW-1:0]    tag_i,
  input  logic [WAYS-1:0]              way_en_i,
  output sacl_pkg::line_t [WAYS-1:0]   row_o,
  output sacl_pkg::lookup_res_t        res_o
);
  import sacl_pkg::*;

  localparam int unsigned WidxW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned Leaves = 1 << $clog2(WAYS);
  localparam int unsigned Nodes  = 2 * Leaves - 1;

  logic [WAYS-1:0]  match;
  logic             hit;
  logic [WidxW-1:0] hit_way;
  logic             have_inv;
  logic [WidxW-1:0] inv_way;
  logic [WidxW-1:0] used_way;

  logic             nd_cand [Nodes];
  logic [AgeW-1:0]  nd_age  [Nodes];
  logic [WidxW-1:0] nd_idx  [Nodes];

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    have_inv = 1'b0;
    inv_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = way_en_i[w] && row_i[w].valid && (row_i[w].tag == tag_i);
      if (match[w] && !hit) begin
        hit     = 1'b1;
        hit_way = WidxW'(w);
      end
      if (way_en_i[w] && !row_i[w].valid && !have_inv) begin
        have_inv = 1'b1;
        inv_way  = WidxW'(w);
      end
    end
  end

  // oldest-way tree; left side wins ties so the lowest way is picked
  always_comb begin
    for (int i = 0; i < Leaves; i++) begin
      if (i < WAYS) begin
        nd_cand[Leaves-1+i] = way_en_i[i];
        nd_age[Leaves-1+i]  = row_i[i].age;
      end else begin
        nd_cand[Leaves-1+i] = 1'b0;
        nd_age[Leaves-1+i]  = '0;
      end
      nd_idx[Leaves-1+i] = WidxW'(i);
    end
    for (int n = int'(Leaves) - 2; n >= 0; n--) begin
      if (nd_cand[2*n+1] && (!nd_cand[2*n+2] || nd_age[2*n+1] >= nd_age[2*n+2])) begin
        nd_cand[n] = nd_cand[2*n+1];
        nd_age[n]  = nd_age[2*n+1];
        nd_idx[n]  = nd_idx[2*n+1];
      end else begin
        nd_cand[n] = nd_cand[2*n+2];
        nd_age[n]  = nd_age[2*n+2];
        nd_idx[n]  = nd_idx[2*n+2];
      end
    end
  end

  always_comb begin
    priority if (hit) begin
      used_way = hit_way;
    end else if (have_inv) begin
      used_way = inv_way;
    end else begin
      used_way = nd_idx[0];
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_o[w] = row_i[w];
      if (way_en_i[w]) begin
        if (used_way == WidxW'(w)) begin
          row_o[w].age = '0;
          if (!hit) begin
            row_o[w].valid = 1'b1;
            row_o[w].tag   = tag_i;
          end
        end else if (row_i[w].age != {AgeW{1'b1}}) begin
          row_o[w].age = row_i[w].age + AgeW'(1);
        end
      end
    end
  end

  assign res_o.hit   = hit;
  assign res_o.evict = !hit && !have_inv;

endmodule

FILE: hw/rtl/set_assoc_lru_cache_sim_unit.sv
// An accepted transaction is registered into the s1 stage, looked up, and its result
// registered onto valid_o; one transaction per cycle while busy is low.
// Throughput is set by the one-row read of the line store plus a forward of the
// row written in the same cycle. Instruction fetches give no result.
// After reset, busy stays high while the store is cleared
// one row per cycle. The receiver cannot stall; results are never held off.
module set_assoc_lru_cache_sim_unit #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned WAYS         = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [31:0] address_i,
  output logic        valid_o,
  output logic        was_hit_o,
  output logic        was_evicted_o,
  output logic [31:0] total_hits_o,
  output logic [31:0] total_misses_o,
  output logic [31:0] total_evictions_o
);
  import sacl_pkg::*;

  localparam int unsigned SetW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned NumSets = 1 << MAX_SET_BITS;

  logic [2:0] set_bits_q;
  logic [4:0] block_bits_q;
  logic [2:0] ways_q;

  logic            clr_active_q;
  logic [SetW-1:0] clr_cnt_q;

  logic            accept;
  logic [2:0]      sb;
  logic [31:0]     shifted;
  logic [31:0]     set_full;
  logic [SetW-1:0] set_in;
  logic [5:0]      tag_shift;
  logic [TagW-1:0] tag_in;
  logic [WAYS-1:0] way_en;
  logic [2:0]      eff_ways;

  logic            s1_valid_q;
  logic            s1_modify_q;
  logic [SetW-1:0] s1_set_q;
  logic [TagW-1:0] s1_tag_q;

  logic             fwd_q;
  line_t [WAYS-1:0] fwd_row_q;
  line_t [WAYS-1:0] rd_row;
  line_t [WAYS-1:0] cur_row;
  line_t [WAYS-1:0] new_row;
  line_t [WAYS-1:0] wr_row;
  lookup_res_t      res;

  logic            wr_en;
  logic [SetW-1:0] wr_addr;

  logic        valid_q;
  logic        was_hit_q;
  logic        was_evicted_q;
  logic [31:0] hits_q, hits_d;
  logic [31:0] misses_q;
  logic [31:0] evicts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd4;
      block_bits_q <= 5'd4;
      ways_q       <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[2:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        CFG_WAYS:       ways_q       <= cfg_data_i[2:0];
        default:        ;
      endcase
    end
  end

  // address split
  always_comb begin
    sb        = (32'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
    shifted   = address_i >> block_bits_q;
    set_full  = shifted & ((32'd1 << sb) - 32'd1);
    set_in    = set_full[SetW-1:0];
    tag_shift = 6'(block_bits_q) + 6'(sb);
    tag_in    = tag_shift[5] ? '0 : (address_i >> tag_shift[4:0]);
  end

  always_comb begin
    if (ways_q == 3'd0) begin
      eff_ways = 3'd1;
    end else if (32'(ways_q) > WAYS) begin
      eff_ways = 3'(WAYS);
    end else begin
      eff_ways = ways_q;
    end
    for (int w = 0; w < WAYS; w++) begin
      way_en[w] = 32'(w) < 32'(eff_ways);
    end
  end

  assign busy   = clr_active_q;
  assign accept = start && !clr_active_q;

  // post-reset clearing pass over all rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + SetW'(1);
      if (clr_cnt_q == SetW'(NumSets - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept && (kind_i != KIND_INSTR);
      fwd_q      <= s1_valid_q && (s1_set_q == set_in);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_modify_q <= (kind_i == KIND_MODIFY);
    s1_set_q    <= set_in;
    s1_tag_q    <= tag_in;
    fwd_row_q   <= new_row;
  end

  sacl_store #(
    .WAYS     (WAYS),
    .SET_W    (SetW),
    .NUM_SETS (NumSets)
  ) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (set_in),
    .rd_row_o  (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_row_i  (wr_row)
  );

  // the row written at the read edge is taken from the forward register
  assign cur_row = fwd_q ? fwd_row_q : rd_row;

  sacl_lookup #(
    .WAYS (WAYS)
  ) u_lookup (
    .row_i    (cur_row),
    .tag_i    (s1_tag_q),
    .way_en_i (way_en),
    .row_o    (new_row),
    .res_o    (res)
  );

  assign wr_en   = clr_active_q || s1_valid_q;
  assign wr_addr = clr_active_q ? clr_cnt_q : s1_set_q;
  assign wr_row  = clr_active_q ? '0 : new_row;

  always_comb begin
    hits_d = hits_q;
    if (res.hit) begin
      hits_d = hits_q + (s1_modify_q ? 32'd2 : 32'd1);
    end else if (s1_modify_q) begin
      hits_d = hits_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else begin
      valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        hits_q <= hits_d;
        if (!res.hit) begin
          misses_q <= misses_q + 32'd1;
        end
        if (res.evict) begin
          evicts_q <= evicts_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    was_hit_q     <= res.hit;
    was_evicted_q <= res.evict;
  end

  assign valid_o           = valid_q;
  assign was_hit_o         = was_hit_q;
  assign was_evicted_o     = was_evicted_q;
  assign total_hits_o      = hits_q;
  assign total_misses_o    = misses_q;
  assign total_evictions_o = evicts_q;

  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s1_valid_q)
    else $error("lookup active during clearing pass");

  a_hit_xor_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(was_hit_o && was_evicted_o))
    else $error("hit reported together with eviction");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (total_misses_o == $past(total_misses_o) + 32'(!was_hit_o)))
    else $error("miss total out of step with result");

  a_evict_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (total_evictions_o == $past(total_evictions_o) + 32'(was_evicted_o)))
    else $error("eviction total out of step with result");

endmodule
